@@ design/stpq_pkg.sv @@
// Shared types and constants for the sorted task priority queue.
// No dependencies; used by the slot RAM and the top level.
package stpq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int KEY_BITS    = 32;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] sort_key;
    logic [7:0]  task_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  out_task_id;
    logic [31:0] out_key;
    logic [4:0]  entry_count;
  } out_item_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [7:0]          id;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } wr_req_t;

endpackage

@@ design/sorted_task_priority_queue.sv @@
// Sorted task priority queue: entries kept in ascending key order in one RAM.
// A rejected or unused command goes straight to the result; insert reads entries
// down from the tail (those shifted up plus the smaller one that stops the walk)
// and then writes the new entry; pop/remove read every entry held;
// the slot RAM walk, one read and one compare per entry, sets the rate.
// One command in flight; a new item is taken while a result waits.
// Synchronous active-low reset clears the entry count and control; no RAM clear.
module sorted_task_priority_queue
  import stpq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_CHK  = 5'b00100,
    S_PUT  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    fill_r, fill_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [IDX_W-1:0]    pos_r, pos_nxt;
  logic                found_r, found_nxt;
  logic [1:0]          cmd_r, cmd_nxt;
  entry_t              new_r, new_nxt;
  logic [1:0]          res_status_r, res_status_nxt;
  entry_t              res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  wr_req_t             wr;
  logic [IDX_W-1:0]    rd_addr;
  entry_t              rd_data;
  logic                match;
  logic                last;

  stpq_slot_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign rd_addr   = idx_r;

  assign match = (cmd_r == CMD_POP) ? (idx_r == '0) : (rd_data.id == new_r.id);
  assign last  = ((CNT_W'(idx_r) + CNT_W'(1)) == fill_r);

  // Insert walks down from the tail shifting entries up; pop/remove walk up
  // from the head and pull entries behind the hit down. Writes land two slots
  // away from the next read, so no forwarding is needed.
  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    found_nxt      = found_r;
    cmd_nxt        = cmd_r;
    new_nxt        = new_r;
    res_status_nxt = res_status_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    wr             = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt        = in_data.cmd;
          new_nxt.key    = KEY_BITS'(in_data.sort_key);
          new_nxt.id     = in_data.task_id;
          res_status_nxt = ST_OK;
          res_nxt        = '0;
          found_nxt      = 1'b0;
          state_nxt      = S_FIN;
          case (in_data.cmd)
            CMD_INSERT: begin
              if (fill_r == CNT_W'(QUEUE_DEPTH)) begin
                res_status_nxt = ST_FULL;
              end else if (fill_r == '0) begin
                pos_nxt   = '0;
                state_nxt = S_PUT;
              end else begin
                idx_nxt   = IDX_W'(fill_r - CNT_W'(1));
                state_nxt = S_RD;
              end
            end
            CMD_POP, CMD_REMOVE: begin
              if (fill_r == '0) begin
                res_status_nxt = (in_data.cmd == CMD_POP) ? ST_EMPTY : ST_NOT_FOUND;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_RD;
              end
            end
            default: begin
              res_status_nxt = ST_OK;
            end
          endcase
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (cmd_r == CMD_INSERT) begin
          if (rd_data.key >= new_r.key) begin
            wr.en   = 1'b1;
            wr.addr = idx_r + IDX_W'(1);
            wr.data = rd_data;
            if (idx_r == '0) begin
              pos_nxt   = '0;
              state_nxt = S_PUT;
            end else begin
              idx_nxt   = idx_r - IDX_W'(1);
              state_nxt = S_RD;
            end
          end else begin
            pos_nxt   = idx_r + IDX_W'(1);
            state_nxt = S_PUT;
          end
        end else begin
          if (found_r) begin
            wr.en   = 1'b1;
            wr.addr = idx_r - IDX_W'(1);
            wr.data = rd_data;
          end else if (match) begin
            res_nxt   = rd_data;
            found_nxt = 1'b1;
          end
          if (last) begin
            if (found_r || match) begin
              fill_nxt = fill_r - CNT_W'(1);
            end else begin
              res_status_nxt = ST_NOT_FOUND;
            end
            state_nxt = S_FIN;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = S_RD;
          end
        end
      end
      S_PUT: begin
        wr.en     = 1'b1;
        wr.addr   = pos_r;
        wr.data   = new_r;
        fill_nxt  = fill_r + CNT_W'(1);
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = res_status_r;
          out_data_nxt.out_task_id = res_r.id;
          out_data_nxt.out_key     = 32'(res_r.key);
          out_data_nxt.entry_count = 5'(fill_r);
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    cmd_r        <= cmd_nxt;
    new_r        <= new_nxt;
    res_status_r <= res_status_nxt;
    res_r        <= res_nxt;
    out_data_r   <= out_data_nxt;
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (state_r == S_CHK || state_r == S_PUT))
    else $error("slot write outside a walk or put step");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_PUT && state_r != S_CHK) |=> $stable(fill_r))
    else $error("entry count changed outside an update step");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && res_status_r == ST_FULL) |-> fill_r == CNT_W'(QUEUE_DEPTH))
    else $error("full status reported with free slots");
`endif

endmodule

@@ design/stpq_slot_ram.sv @@
// Slot storage: one write port, one read port, registered read data.
// Depends on stpq_pkg for the entry and write request types.
module stpq_slot_ram
  import stpq_pkg::*;
(
  input  logic             clk,
  input  wr_req_t          wr,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data
);

  entry_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ tb/sorted_task_priority_queue_tb.sv @@
// Self-checking testbench for the sorted task priority queue.
// Depends on stpq_pkg and sorted_task_priority_queue; a class-based tracker predicts every reply.
module sorted_task_priority_queue_tb;
  import stpq_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 2000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_TAIL   = 60;
  localparam int CYCLE_LIMIT  = 1_500_000;

  // Mirrors the queue contents and holds the replies still owed by the block.
  class task_queue_tracker;
    entry_t      slots[QUEUE_DEPTH];
    int          fill;
    int          peak_fill;
    out_item_t   expected_replies[$];
    int unsigned mismatches;
    int unsigned replies_checked;
    int unsigned status_seen[4];

    function new();
      fill = 0;
      peak_fill = 0;
      mismatches = 0;
      replies_checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void drop_entry(int pos);
      for (int i = pos; i + 1 < fill; i++) slots[i] = slots[i + 1];
      fill--;
    endfunction

    function void note_command(in_item_t cmd_item);
      out_item_t           reply;
      logic [KEY_BITS-1:0] key;
      int                  pos;
      reply = '0;
      reply.status = ST_OK;
      key = cmd_item.sort_key[KEY_BITS-1:0];
      case (cmd_item.cmd)
        CMD_INSERT: begin
          if (fill >= QUEUE_DEPTH) begin
            reply.status = ST_FULL;
          end else begin
            // new entry goes ahead of any equal key
            pos = 0;
            while (pos < fill && slots[pos].key < key) pos++;
            for (int i = fill; i > pos; i--) slots[i] = slots[i - 1];
            slots[pos].key = key;
            slots[pos].id  = cmd_item.task_id;
            fill++;
          end
        end
        CMD_POP: begin
          if (fill == 0) begin
            reply.status = ST_EMPTY;
          end else begin
            reply.out_task_id = slots[0].id;
            reply.out_key     = 32'(slots[0].key);
            drop_entry(0);
          end
        end
        CMD_REMOVE: begin
          pos = 0;
          while (pos < fill && slots[pos].id != cmd_item.task_id) pos++;
          if (pos == fill) begin
            reply.status = ST_NOT_FOUND;
          end else begin
            reply.out_task_id = slots[pos].id;
            reply.out_key     = 32'(slots[pos].key);
            drop_entry(pos);
          end
        end
        default: ;
      endcase
      reply.entry_count = 5'(fill);
      if (fill > peak_fill) peak_fill = fill;
      expected_replies.push_back(reply);
    endfunction

    function void check_reply(out_item_t got);
      out_item_t want;
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] reply with nothing pending: status=%0d id=%0d key=%h count=%0d",
                   $time, got.status, got.out_task_id, got.out_key, got.entry_count);
        return;
      end
      want = expected_replies.pop_front();
      replies_checked++;
      status_seen[want.status]++;
      if (got.status !== want.status || got.out_task_id !== want.out_task_id ||
          got.out_key !== want.out_key || got.entry_count !== want.entry_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"[%0t] reply %0d: expected status=%0d id=%0d key=%h count=%0d,",
                    " got status=%0d id=%0d key=%h count=%0d"},
                   $time, replies_checked, want.status, want.out_task_id, want.out_key,
                   want.entry_count, got.status, got.out_task_id, got.out_key,
                   got.entry_count);
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  task_queue_tracker tracker;
  int hold_requests = 0;
  int holds_done = 0;
  int src_calm = 0;
  int sink_calm = 0;
  int cycles = 0;

  sorted_task_priority_queue uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial tracker = new();

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) tracker.note_command(in_data);
      if (out_valid && out_ready) tracker.check_reply(out_data);
    end
  end

  // mostly short gaps, a few long ones, and now and then a calm stretch
  function automatic int pick_gap(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 199) == 0) calm_left = 40;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(input in_item_t item);
    int gap;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    gap = pick_gap(src_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_cmd(input logic [1:0] op, input logic [31:0] key, input logic [7:0] id);
    in_item_t item;
    item.cmd      = op;
    item.sort_key = key;
    item.task_id  = id;
    send_item(item);
  endtask

  // lean: 0 leans toward inserts, 1 toward pops and removes, 2 even
  function automatic in_item_t random_command(int lean);
    in_item_t item;
    int       r;
    int       insert_pct;
    insert_pct = (lean == 0) ? 70 : (lean == 1) ? 25 : 45;
    r = $urandom_range(0, 99);
    if (r < 3)                    item.cmd = CMD_UNUSED;
    else if (r < 3 + insert_pct)  item.cmd = CMD_INSERT;
    else if ($urandom_range(0, 1)) item.cmd = CMD_POP;
    else                          item.cmd = CMD_REMOVE;
    r = $urandom_range(0, 9);
    if (r < 3) begin
      item.sort_key = $urandom_range(0, 15);  // dense keys give ties
    end else if (r == 3) begin
      case ($urandom_range(0, 3))
        0:       item.sort_key = 32'h0000_0000;
        1:       item.sort_key = 32'h0000_0001;
        2:       item.sort_key = 32'hFFFF_FFFE;
        default: item.sort_key = 32'hFFFF_FFFF;
      endcase
    end else begin
      item.sort_key = $urandom;
    end
    // small id pool so removes usually hit, with duplicates
    if ($urandom_range(0, 4) == 0) item.task_id = 8'($urandom_range(0, 255));
    else                           item.task_id = 8'($urandom_range(0, 23));
    return item;
  endfunction

  // result side
  initial begin
    int gap;
    out_ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_requests != holds_done) begin
        holds_done++;
        gap = LONG_HOLD;
      end else begin
        gap = pick_gap(sink_calm);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Run stopped after %0d cycles with %0d replies outstanding",
             cycles, tracker.expected_replies.size());
    $display("FAILURE");
    $finish;
  end

  initial begin
    int sent;
    int n;
    int lean;
    int lean_left;
    in_item_t item;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty queue, unused command, ties, duplicates, full queue
    send_cmd(CMD_POP,    32'h0000_0000, 8'h00);
    send_cmd(CMD_REMOVE, 32'h0000_0000, 8'h00);
    send_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 8'hFF);
    send_cmd(CMD_INSERT, 32'h0000_0000, 8'h00);
    send_cmd(CMD_INSERT, 32'hFFFF_FFFF, 8'hFF);
    send_cmd(CMD_INSERT, 32'h0000_0005, 8'h07);
    send_cmd(CMD_INSERT, 32'h0000_0005, 8'h09);
    send_cmd(CMD_INSERT, 32'h0000_0005, 8'h07);
    send_cmd(CMD_REMOVE, 32'h0000_0000, 8'h07);
    send_cmd(CMD_REMOVE, 32'h0000_0000, 8'h2A);
    send_cmd(CMD_POP,    32'h0000_0000, 8'h00);
    for (int i = 0; i < QUEUE_DEPTH - 3; i++)
      send_cmd(CMD_INSERT, 32'h8000_0000 - 32'(i * 7), 8'(100 + i));
    send_cmd(CMD_INSERT, 32'h0000_0003, 8'hAA);
    send_cmd(CMD_UNUSED, 32'h0000_0000, 8'h00);
    send_cmd(CMD_REMOVE, 32'h0000_0000, 8'hFF);

    sent = 0;
    n = 0;
    lean = 2;
    lean_left = 0;
    while (sent < RANDOM_ITEMS) begin
      if (lean_left == 0) begin
        lean = $urandom_range(0, 2);
        lean_left = $urandom_range(30, 150);
      end
      lean_left--;
      // block fills and backs up while the result side holds off
      if (n == 400 || n == 1400) hold_requests <= hold_requests + 1;
      if (n == 1000) begin
        in_valid <= 1'b0;
        // step off the accepting edge so the last item is already noted
        do @(negedge clk); while (tracker.expected_replies.size() != 0);
        @(posedge clk);
      end
      item = random_command(lean);
      send_item(item);
      if (item.cmd != CMD_UNUSED) sent++;
      n++;
    end
    in_valid <= 1'b0;

    do @(negedge clk); while (tracker.expected_replies.size() != 0);
    repeat (DRAIN_TAIL) @(posedge clk);

    $display("Checked %0d replies: %0d ok, %0d empty, %0d full, %0d not found",
             tracker.replies_checked, tracker.status_seen[ST_OK],
             tracker.status_seen[ST_EMPTY], tracker.status_seen[ST_FULL],
             tracker.status_seen[ST_NOT_FOUND]);
    $display("Deepest fill %0d of %0d, %0d mismatches, %0d replies never seen",
             tracker.peak_fill, QUEUE_DEPTH, tracker.mismatches,
             tracker.expected_replies.size());
    if (tracker.mismatches == 0 && tracker.expected_replies.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ sorted_task_priority_queue.f @@
design/stpq_pkg.sv
design/stpq_slot_ram.sv
design/sorted_task_priority_queue.sv
tb/sorted_task_priority_queue_tb.sv
